[design/lpfp_pkg.sv]
// ----------------------------------------------------------------------------
// lpfp_pkg
// Shared types and constants of the length-prefixed frame parser.
// ----------------------------------------------------------------------------
package lpfp_pkg;

  localparam int LENGTH_BITS      = 16;
  localparam int MAX_LENGTH_CHARS = 10;
  localparam int DIGIT_CNT_BITS   = 4;
  localparam int FIELD_BITS       = 2;

  localparam logic [FIELD_BITS-1:0] FIELD_SAT = 2'd3;

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_C      = 8'h43;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_EMPTY = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] field_index;
    logic [7:0] data_byte;
    logic       last_of_field;
  } result_t;

endpackage

[design/lpfp_in_if.sv]
// ----------------------------------------------------------------------------
// lpfp_in_if
// Byte channel into the parser: valid/ready with one raw byte.
// ----------------------------------------------------------------------------
interface lpfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

[design/lpfp_out_if.sv]
// ----------------------------------------------------------------------------
// lpfp_out_if
// Result channel of the parser: valid/ready with one tagged result.
// ----------------------------------------------------------------------------
interface lpfp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [1:0] field_index;
  logic [7:0] data_byte;
  logic       last_of_field;

  modport source (output valid, output kind, output field_index, output data_byte,
                  output last_of_field, input ready);
  modport sink (input valid, input kind, input field_index, input data_byte,
                input last_of_field, output ready);
endinterface

[design/lpfp_parse.sv]
// ----------------------------------------------------------------------------
// lpfp_parse
// Parse state and the combinational next-state / result logic for one byte.
// ----------------------------------------------------------------------------
module lpfp_parse (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  logic [7:0]           byte_in,
  output logic                 res_valid,
  output lpfp_pkg::result_t    res
);

  localparam logic [1:0] PH_WAIT    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  localparam int LB = lpfp_pkg::LENGTH_BITS;
  localparam int WB = LB + 4;
  localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

  logic [1:0]                          phase_r, phase_nxt;
  logic [LB-1:0]                       length_r, length_nxt;
  logic [LB-1:0]                       left_r, left_nxt;
  logic [lpfp_pkg::DIGIT_CNT_BITS-1:0] dcnt_r, dcnt_nxt;
  logic                                dstop_r, dstop_nxt;
  logic [lpfp_pkg::FIELD_BITS-1:0]     field_r, field_nxt;

  logic                                do_end;
  logic                                do_start;
  logic                                do_bump;
  logic                                is_digit;
  logic [WB-1:0]                       acc;
  logic [lpfp_pkg::DIGIT_CNT_BITS-1:0] dcnt_inc;
  logic [LB-1:0]                       left_dec;

  assign is_digit = byte_in inside {[lpfp_pkg::CH_0 : lpfp_pkg::CH_9]};
  // length * 10 + digit, kept wide enough to see the overflow
  assign acc = ({4'd0, length_r} << 3) + ({4'd0, length_r} << 1)
             + {{(WB-8){1'b0}}, byte_in - lpfp_pkg::CH_0};
  assign dcnt_inc = dcnt_r + 1'b1;
  assign left_dec = (left_r != '0) ? left_r - 1'b1 : left_r;

  always_comb begin
    phase_nxt  = phase_r;
    length_nxt = length_r;
    left_nxt   = left_r;
    dcnt_nxt   = dcnt_r;
    dstop_nxt  = dstop_r;
    field_nxt  = field_r;
    res_valid  = 1'b0;
    res        = '0;
    do_end     = 1'b0;
    do_start   = 1'b0;
    do_bump    = 1'b0;

    case (phase_r)
      PH_WAIT: begin
        if (byte_in == lpfp_pkg::CH_LBRACE) begin
          phase_nxt  = PH_HEADER;
          length_nxt = '0;
          left_nxt   = '0;
          dcnt_nxt   = '0;
          dstop_nxt  = 1'b0;
          field_nxt  = '0;
        end
      end
      PH_HEADER: begin
        if (byte_in == lpfp_pkg::CH_RBRACE) begin
          do_end = 1'b1;
        end else if (byte_in == lpfp_pkg::CH_L) begin
          phase_nxt  = PH_DIGITS;
          length_nxt = '0;
          dcnt_nxt   = '0;
          dstop_nxt  = 1'b0;
        end else if (byte_in == lpfp_pkg::CH_C) begin
          do_start = 1'b1;
        end
      end
      PH_DIGITS: begin
        if (byte_in == lpfp_pkg::CH_RBRACE) begin
          do_end = 1'b1;
        end else if (byte_in == lpfp_pkg::CH_C) begin
          do_start = 1'b1;
        end else begin
          if (!dstop_r && is_digit) begin
            length_nxt = (acc[WB-1:LB] != '0) ? LEN_MAX : acc[LB-1:0];
          end else begin
            dstop_nxt = 1'b1;
          end
          dcnt_nxt = dcnt_inc;
          if (dcnt_inc >= lpfp_pkg::DIGIT_CNT_BITS'(lpfp_pkg::MAX_LENGTH_CHARS)) begin
            phase_nxt = PH_HEADER;
          end
        end
      end
      default: begin
        left_nxt = left_dec;
        if (left_dec == '0) begin
          phase_nxt = PH_HEADER;
          do_bump   = 1'b1;
        end
        if (field_r != lpfp_pkg::FIELD_SAT) begin
          res_valid         = 1'b1;
          res.kind          = lpfp_pkg::KIND_BYTE;
          res.field_index   = field_r;
          res.data_byte     = byte_in;
          res.last_of_field = (left_r <= LB'(1));
        end
      end
    endcase

    if (do_end) begin
      phase_nxt = PH_WAIT;
      field_nxt = '0;
      left_nxt  = '0;
      res_valid = 1'b1;
      res.kind  = lpfp_pkg::KIND_END;
    end

    if (do_start) begin
      if (length_r == '0) begin
        // empty field: one marker unless the field count is saturated, nothing more consumed
        phase_nxt = PH_HEADER;
        do_bump   = 1'b1;
        if (field_r != lpfp_pkg::FIELD_SAT) begin
          res_valid         = 1'b1;
          res.kind          = lpfp_pkg::KIND_EMPTY;
          res.field_index   = field_r;
          res.last_of_field = 1'b1;
        end
      end else begin
        left_nxt  = length_r;
        phase_nxt = PH_PAYLOAD;
      end
    end

    if (do_bump && field_r != lpfp_pkg::FIELD_SAT) begin
      field_nxt = field_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_WAIT;
      length_r <= '0;
      left_r   <= '0;
      dcnt_r   <= '0;
      dstop_r  <= 1'b0;
      field_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      length_r <= length_nxt;
      left_r   <= left_nxt;
      dcnt_r   <= dcnt_nxt;
      dstop_r  <= dstop_nxt;
      field_r  <= field_nxt;
    end
  end

`ifndef SYNTHESIS
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> left_r != '0)
    else $error("payload phase with no bytes left");

  a_wait_no_fields: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_WAIT |-> field_r == '0)
    else $error("field count not cleared outside a frame");

  a_digit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_DIGITS
      |-> dcnt_r < lpfp_pkg::DIGIT_CNT_BITS'(lpfp_pkg::MAX_LENGTH_CHARS))
    else $error("length character count past its limit");

  a_end_leaves_frame: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_valid && res.kind == lpfp_pkg::KIND_END |=> phase_r == PH_WAIT)
    else $error("frame end did not return to waiting");
`endif

endmodule

[design/lpfp_out_reg.sv]
// ----------------------------------------------------------------------------
// lpfp_out_reg
// Result register: holds one result until the sink takes the transfer.
// ----------------------------------------------------------------------------
module lpfp_out_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  lpfp_pkg::result_t  res,
  output logic               free,
  lpfp_out_if.source         out_if
);

  logic              valid_r;
  lpfp_pkg::result_t data_r;

  assign free = !valid_r || out_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      data_r <= res;
    end
  end

  assign out_if.valid         = valid_r;
  assign out_if.kind          = data_r.kind;
  assign out_if.field_index   = data_r.field_index;
  assign out_if.data_byte     = data_r.data_byte;
  assign out_if.last_of_field = data_r.last_of_field;

endmodule

[design/length_prefixed_frame_parser_core.sv]
// ----------------------------------------------------------------------------
// length_prefixed_frame_parser_core
// Parses {L<len>C<payload>...} frames and emits tagged payload bytes and markers.
// A byte taken in is held in the input register, and its result in the result register.
// Throughput: one byte per cycle while no waiting result holds it back.
// A waiting result holds back only a byte that gives a result; others still advance.
// Reset (synchronous, active low) empties both registers and waits for '{'.
// ----------------------------------------------------------------------------
module length_prefixed_frame_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  lpfp_in_if.sink     in_if,
  lpfp_out_if.source  out_if
);

  logic              in_valid_r;
  logic [7:0]        in_byte_r;
  logic              step;
  logic              res_valid;
  lpfp_pkg::result_t res;
  logic              out_free;

  // advance a byte with no result even when the output is blocked
  assign step        = in_valid_r && (out_free || !res_valid);
  assign in_if.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      in_byte_r <= in_if.in_byte;
    end
  end

  lpfp_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (in_byte_r),
    .res_valid (res_valid),
    .res       (res)
  );

  lpfp_out_reg u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (step && res_valid),
    .res    (res),
    .free   (out_free),
    .out_if (out_if)
  );

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives byte streams of {L<len>C<payload>...} frames into the parser under
// random idling and back-pressure, predicts each tagged result and checks
// every transfer on the result channel field by field, in order.
// ----------------------------------------------------------------------------
module testbench;

  typedef enum logic [1:0] {
    PH_WAIT    = 2'd0,
    PH_HEADER  = 2'd1,
    PH_DIGITS  = 2'd2,
    PH_PAYLOAD = 2'd3
  } parse_phase_e;

  typedef logic [7:0] octet_t;

  class frame_scoreboard;
    parse_phase_e                          phase;
    logic [lpfp_pkg::LENGTH_BITS-1:0]      length_value;
    logic [lpfp_pkg::LENGTH_BITS-1:0]      bytes_left;
    logic [lpfp_pkg::DIGIT_CNT_BITS-1:0]   digit_count;
    bit                                    digits_stopped;
    logic [lpfp_pkg::FIELD_BITS-1:0]       field_count;
    lpfp_pkg::result_t                     expected_q[$];
    int                                    errors;

    function new();
      phase          = PH_WAIT;
      length_value   = '0;
      bytes_left     = '0;
      digit_count    = '0;
      digits_stopped = 1'b0;
      field_count    = '0;
      errors         = 0;
    endfunction

    function void bump_field();
      if (field_count < lpfp_pkg::FIELD_SAT) field_count++;
    endfunction

    function bit close_frame(output lpfp_pkg::result_t r);
      phase          = PH_WAIT;
      field_count    = '0;
      bytes_left     = '0;
      r.kind          = lpfp_pkg::KIND_END;
      r.field_index   = '0;
      r.data_byte     = '0;
      r.last_of_field = 1'b0;
      return 1'b1;
    endfunction

    function bit open_payload(output lpfp_pkg::result_t r);
      logic [lpfp_pkg::FIELD_BITS-1:0] f;
      f = field_count;
      r = '0;
      if (length_value == '0) begin
        // empty field: one marker unless the field count is saturated, next byte is a header byte again
        phase = PH_HEADER;
        bump_field();
        if (f < lpfp_pkg::FIELD_SAT) begin
          r.kind          = lpfp_pkg::KIND_EMPTY;
          r.field_index   = f;
          r.last_of_field = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      bytes_left = length_value;
      phase      = PH_PAYLOAD;
      return 1'b0;
    endfunction

    function bit parse_byte(octet_t b, output lpfp_pkg::result_t r);
      bit                              hit;
      logic [lpfp_pkg::FIELD_BITS-1:0] f;
      bit                              last;
      longint unsigned                 acc;
      longint unsigned                 len_max;
      hit     = 1'b0;
      r       = '0;
      len_max = (64'd1 << lpfp_pkg::LENGTH_BITS) - 1;
      case (phase)
        PH_WAIT: begin
          if (b == lpfp_pkg::CH_LBRACE) begin
            phase          = PH_HEADER;
            length_value   = '0;
            bytes_left     = '0;
            digit_count    = '0;
            digits_stopped = 1'b0;
            field_count    = '0;
          end
        end
        PH_HEADER: begin
          if (b == lpfp_pkg::CH_RBRACE) begin
            hit = close_frame(r);
          end else if (b == lpfp_pkg::CH_L) begin
            phase          = PH_DIGITS;
            length_value   = '0;
            digit_count    = '0;
            digits_stopped = 1'b0;
          end else if (b == lpfp_pkg::CH_C) begin
            hit = open_payload(r);
          end
        end
        PH_DIGITS: begin
          if (b == lpfp_pkg::CH_RBRACE) begin
            hit = close_frame(r);
          end else if (b == lpfp_pkg::CH_C) begin
            hit = open_payload(r);
          end else begin
            if (!digits_stopped && b >= lpfp_pkg::CH_0 && b <= lpfp_pkg::CH_9) begin
              acc = longint'(length_value) * 10 + longint'(b - lpfp_pkg::CH_0);
              length_value = (acc > len_max) ? len_max[lpfp_pkg::LENGTH_BITS-1:0]
                                             : acc[lpfp_pkg::LENGTH_BITS-1:0];
            end else begin
              digits_stopped = 1'b1;
            end
            digit_count++;
            if (digit_count >= lpfp_pkg::MAX_LENGTH_CHARS) phase = PH_HEADER;
          end
        end
        default: begin
          f    = field_count;
          last = (bytes_left <= 1);
          if (bytes_left > 0) bytes_left--;
          if (bytes_left == 0) begin
            phase = PH_HEADER;
            bump_field();
          end
          if (f < lpfp_pkg::FIELD_SAT) begin
            r.kind          = lpfp_pkg::KIND_BYTE;
            r.field_index   = f;
            r.data_byte     = b;
            r.last_of_field = last;
            hit = 1'b1;
          end
        end
      endcase
      return hit;
    endfunction

    function void note_input(octet_t b);
      lpfp_pkg::result_t r;
      if (parse_byte(b, r)) expected_q.insert(expected_q.size(), r);
    endfunction

    function void report(string what, int want, int got);
      errors++;
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
    endfunction

    function void check_result(lpfp_pkg::result_t got);
      lpfp_pkg::result_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, actual kind %0d field %0d data %0d",
                 $time, got.kind, got.field_index, got.data_byte);
        return;
      end
      want = expected_q.pop_front();
      if (got.kind !== want.kind) report("kind", want.kind, got.kind);
      if (got.field_index !== want.field_index)
        report("field_index", want.field_index, got.field_index);
      if (got.data_byte !== want.data_byte) report("data_byte", want.data_byte, got.data_byte);
      if (got.last_of_field !== want.last_of_field)
        report("last_of_field", want.last_of_field, got.last_of_field);
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lpfp_in_if  in_if();
  lpfp_out_if out_if();

  length_prefixed_frame_parser_core uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  frame_scoreboard sb;
  frame_scoreboard shadow;    // tracks the parse state of what has been queued
  octet_t          pending_q[$];
  int              idle_pct;
  int              stall_pct;
  int              hold_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      out_if.ready <= 1'b0;
      hold_cycles--;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) sb.note_input(in_if.in_byte);
      if (out_if.valid && out_if.ready)
        sb.check_result('{kind: out_if.kind, field_index: out_if.field_index,
                          data_byte: out_if.data_byte, last_of_field: out_if.last_of_field});
    end
  end

  function automatic void push_byte(octet_t b);
    lpfp_pkg::result_t r;
    void'(shadow.parse_byte(b, r));
    pending_q.insert(pending_q.size(), b);
  endfunction

  function automatic octet_t noise_byte();
    case ($urandom_range(0, 15))
      0:       return lpfp_pkg::CH_LBRACE;
      1:       return lpfp_pkg::CH_RBRACE;
      2:       return lpfp_pkg::CH_L;
      3:       return lpfp_pkg::CH_C;
      4:       return octet_t'(lpfp_pkg::CH_0 + $urandom_range(0, 9));
      default: return octet_t'($urandom_range(0, 255));
    endcase
  endfunction

  // a byte that neither counts as a digit nor steers the header
  function automatic octet_t junk_byte();
    octet_t b;
    do begin
      b = octet_t'($urandom_range(0, 255));
    end while ((b >= lpfp_pkg::CH_0 && b <= lpfp_pkg::CH_9) || b == lpfp_pkg::CH_L
               || b == lpfp_pkg::CH_C || b == lpfp_pkg::CH_RBRACE);
    return b;
  endfunction

  function automatic int pick_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 0;
    if (r < 90) return $urandom_range(1, 8);
    if (r < 98) return $urandom_range(9, 40);
    return $urandom_range(41, 300);
  endfunction

  function automatic void push_decimal(int n, int width);
    int dv[10];
    int nd;
    nd = 0;
    do begin
      dv[nd] = n % 10;
      n = n / 10;
      nd++;
    end while (n > 0);
    for (int i = nd; i < width; i++) push_byte(lpfp_pkg::CH_0);
    for (int i = nd - 1; i >= 0; i--) push_byte(octet_t'(lpfp_pkg::CH_0 + dv[i]));
  endfunction

  // bring the queued stream back to waiting for an opening brace
  function automatic void resync();
    while (shadow.phase == PH_PAYLOAD) push_byte(octet_t'($urandom_range(0, 255)));
    if (shadow.phase != PH_WAIT) push_byte(lpfp_pkg::CH_RBRACE);
  endfunction

  function automatic void gen_frame();
    int     nf;
    int     n;
    int     style;
    octet_t b;
    resync();
    if ($urandom_range(0, 99) < 20) begin
      repeat ($urandom_range(1, 3)) begin
        b = noise_byte();
        push_byte((b == lpfp_pkg::CH_LBRACE) ? 8'h00 : b);
      end
    end
    if ($urandom_range(0, 99) < 15) begin
      repeat ($urandom_range(1, 12)) push_byte(noise_byte());
      return;
    end
    push_byte(lpfp_pkg::CH_LBRACE);
    nf = $urandom_range(1, 5);
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(0, 99) < 20) push_byte(junk_byte());
      // a bare C reuses the last length of the frame
      if (i == 0 || $urandom_range(0, 99) >= 20) begin
        n = pick_length();
        push_byte(lpfp_pkg::CH_L);
        if (n != 0 || $urandom_range(0, 1) == 1) begin
          style = $urandom_range(0, 9);
          if (style == 0) begin
            // fill all length characters; the extra digit lands in the header
            push_decimal(n, lpfp_pkg::MAX_LENGTH_CHARS);
            push_byte(octet_t'(lpfp_pkg::CH_0 + $urandom_range(0, 9)));
          end else if (style == 1) begin
            push_decimal(n, $urandom_range(1, lpfp_pkg::MAX_LENGTH_CHARS));
          end else if (style == 2) begin
            push_decimal(n, 1);
            push_byte(junk_byte());
            if ($urandom_range(0, 1) == 1)
              push_byte(octet_t'(lpfp_pkg::CH_0 + $urandom_range(0, 9)));
          end else begin
            push_decimal(n, 1);
          end
        end
      end
      push_byte(lpfp_pkg::CH_C);
      while (shadow.phase == PH_PAYLOAD) push_byte(noise_byte());
    end
    if ($urandom_range(0, 99) < 90) push_byte(lpfp_pkg::CH_RBRACE);
  endfunction

  task automatic send_pending();
    while (pending_q.size() > 0 || in_if.valid) begin
      @(posedge clk);
      if (in_if.valid && in_if.ready) void'(pending_q.pop_front());
      // hold the offered byte until its transfer
      if (!(in_if.valid && !in_if.ready)) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
          in_if.valid   <= 1'b1;
          in_if.in_byte <= pending_q[0];
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic drain_results();
    int guard;
    guard = 0;
    while (sb.expected_q.size() > 0 && guard < 200_000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
  endtask

  initial begin
    octet_t directed[];
    int     idle_set[4];
    int     stall_set[4];

    directed = '{8'h00, lpfp_pkg::CH_RBRACE, 8'hFF, lpfp_pkg::CH_LBRACE,
                 lpfp_pkg::CH_LBRACE, lpfp_pkg::CH_L, lpfp_pkg::CH_0, lpfp_pkg::CH_C,
                 lpfp_pkg::CH_L, 8'h32, lpfp_pkg::CH_C, lpfp_pkg::CH_RBRACE,
                 lpfp_pkg::CH_LBRACE, lpfp_pkg::CH_C, 8'h00, 8'hFF,
                 lpfp_pkg::CH_C, 8'h61, 8'h62, lpfp_pkg::CH_L, lpfp_pkg::CH_C,
                 lpfp_pkg::CH_RBRACE, lpfp_pkg::CH_LBRACE, lpfp_pkg::CH_L,
                 lpfp_pkg::CH_RBRACE};
    idle_set  = '{0, 51, 0, 15};
    stall_set = '{0, 0, 51, 15};

    sb            = new();
    shadow        = new();
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = 8'h00;
    out_if.ready  = 1'b0;
    idle_pct      = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) push_byte(directed[i]);
    send_pending();
    drain_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_set[p];
      stall_pct = stall_set[p];
      while (pending_q.size() < 275) gen_frame();
      if (p == 0) begin
        // saturate the length, then close the frame inside the length characters
        resync();
        push_byte(lpfp_pkg::CH_LBRACE);
        push_byte(lpfp_pkg::CH_L);
        repeat (5) push_byte(8'h39);
        push_byte(lpfp_pkg::CH_RBRACE);
        // stall the result side long enough for the input to back up
        hold_cycles = 400;
      end
      send_pending();
      drain_results();
    end

    if (sb.expected_q.size() != 0) begin
      sb.errors++;
      $display("%0t: results missing: expected %0d more, actual 0",
               $time, sb.expected_q.size());
    end
    if (sb.errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[length_prefixed_frame_parser_core.f]
design/lpfp_pkg.sv
design/lpfp_in_if.sv
design/lpfp_out_if.sv
design/lpfp_parse.sv
design/lpfp_out_reg.sv
design/length_prefixed_frame_parser_core.sv
tb/testbench.sv
